// ===== hw/rtl/n2w_pkg.sv =====
// ----------------------------------------------------------------------------
// n2w_pkg
// shared types, sizes and token codes for the number-to-words block
// ----------------------------------------------------------------------------
package n2w_pkg;

    // input number and decimal conversion sizes
    localparam int NUM_W      = 31;
    localparam int DIGITS     = 10;
    localparam int STEPS      = 16;            // two bits per step
    localparam int SR_W       = 2 * STEPS;     // number padded to whole steps
    localparam int CNT_W      = $clog2(STEPS);

    // token slots: four groups of five, plus the lone zero
    localparam int GROUP_SLOTS = 5;
    localparam int SLOTS       = 4 * GROUP_SLOTS + 1;
    localparam int SLOT_IDX_W  = $clog2(SLOTS);

    typedef logic [3:0] digit_t;
    typedef logic [4:0] token_t;

    // token codes
    localparam token_t TOK_ZERO      = 5'd0;
    localparam token_t TOK_TEEN_BASE = 5'd10;
    localparam token_t TOK_TENS_BASE = 5'd18;
    localparam token_t TOK_BILLION   = 5'd28;
    localparam token_t TOK_MILLION   = 5'd29;
    localparam token_t TOK_THOUSAND  = 5'd30;
    localparam token_t TOK_HUNDRED   = 5'd31;

    // handoff from the converter to the word sequencer
    typedef struct packed {
        logic                    load;
        logic [DIGITS-1:0][3:0]  digits;
    } conv_hand_t;

    // double-dabble correction of one bcd digit
    function automatic digit_t dd_adj(digit_t d);
        digit_t r;
        r = (d >= 4'd5) ? d + 4'd3 : d;
        return r;
    endfunction

endpackage

// ===== hw/rtl/n2w_cell.sv =====
// ----------------------------------------------------------------------------
// n2w_cell
// one bcd digit cell of the binary-to-decimal chain, two shift steps a cycle
// ----------------------------------------------------------------------------
module n2w_cell
    import n2w_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   clear,
    input  logic   step,
    input  logic   in_lo,      // shift-in for the first step
    input  logic   in_hi,      // shift-in for the second step
    output logic   carry_lo,
    output logic   carry_hi,
    output digit_t digit_step,
    output digit_t digit
);

    digit_t digit_reg;
    digit_t digit_next;
    digit_t adj_a;
    digit_t mid;
    digit_t adj_b;

    always_comb
    begin
        adj_a      = dd_adj(digit_reg);
        carry_lo   = adj_a[3];
        mid        = {adj_a[2:0], in_lo};
        adj_b      = dd_adj(mid);
        carry_hi   = adj_b[3];
        digit_step = {adj_b[2:0], in_hi};
    end

    always_comb
    begin
        if (clear)
        begin
            digit_next = '0;
        end
        else if (step)
        begin
            digit_next = digit_step;
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule

// ===== hw/rtl/n2w_conv.sv =====
// ----------------------------------------------------------------------------
// n2w_conv
// binary to bcd converter: shift register feeding a chain of digit cells
// ----------------------------------------------------------------------------
module n2w_conv
    import n2w_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] number,
    input  logic             emit_free,
    output logic             busy,
    output conv_hand_t       hand
);

    logic [SR_W-1:0]  sr_reg;
    logic [SR_W-1:0]  sr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             run_reg;
    logic             run_next;
    logic             full_reg;
    logic             full_next;

    logic             accept;
    logic             last_step;
    logic             load_direct;
    logic             load_full;

    logic [DIGITS-1:0]      c_lo;
    logic [DIGITS-1:0]      c_hi;
    logic [DIGITS-1:0]      in_lo;
    logic [DIGITS-1:0]      in_hi;
    logic [DIGITS-1:0][3:0] d_step;
    logic [DIGITS-1:0][3:0] d_reg;

    // chain of digit cells, least significant first
    genvar gi;
    generate
        for (gi = 0; gi < DIGITS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign in_lo[gi] = sr_reg[SR_W-1];
                assign in_hi[gi] = sr_reg[SR_W-2];
            end
            else
            begin : g_rest
                assign in_lo[gi] = c_lo[gi-1];
                assign in_hi[gi] = c_hi[gi-1];
            end

            n2w_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .clear      (accept),
                .step       (run_reg),
                .in_lo      (in_lo[gi]),
                .in_hi      (in_hi[gi]),
                .carry_lo   (c_lo[gi]),
                .carry_hi   (c_hi[gi]),
                .digit_step (d_step[gi]),
                .digit      (d_reg[gi])
            );
        end
    endgenerate

    always_comb
    begin
        last_step   = run_reg && (cnt_reg == CNT_W'(STEPS - 1));
        load_direct = last_step && emit_free;
        load_full   = full_reg && emit_free;
        busy        = run_reg ? !load_direct : (full_reg && !emit_free);
        accept      = start && !busy;

        hand.load   = load_direct || load_full;
        hand.digits = load_direct ? d_step : d_reg;
    end

    always_comb
    begin
        sr_next   = sr_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        full_next = full_reg;

        if (run_reg)
        begin
            sr_next  = {sr_reg[SR_W-3:0], 2'b00};
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (last_step)
        begin
            run_next  = 1'b0;
            full_next = !emit_free;
        end
        else if (load_full)
        begin
            full_next = 1'b0;
        end
        if (accept)
        begin
            sr_next  = SR_W'(number);
            cnt_next = '0;
            run_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            full_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            full_reg <= full_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg <= sr_next;
    end

endmodule

// ===== hw/rtl/n2w_emit.sv =====
// ----------------------------------------------------------------------------
// n2w_emit
// word sequencer: slot mask built from the digits, one word per cycle
// ----------------------------------------------------------------------------
module n2w_emit
    import n2w_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  conv_hand_t hand,
    output logic       emit_free,
    output logic       word_valid,
    output token_t     word,
    output logic       last_word
);

    logic [SLOTS-1:0]   mask_reg;
    logic [SLOTS-1:0]   mask_next;
    token_t             tok_reg  [SLOTS];
    token_t             tok_new  [SLOTS];
    logic [SLOTS-1:0]   mask_new;

    logic [SLOT_IDX_W-1:0] idx;
    logic                  any;
    logic                  single;

    logic   word_valid_reg;
    logic   word_valid_next;
    token_t word_reg;
    token_t word_next;
    logic   last_word_reg;
    logic   last_word_next;

    digit_t h [4];
    digit_t t [4];
    digit_t u [4];
    token_t scale [4];
    logic   all_zero;

    // group digits: billion, million, thousand, units
    always_comb
    begin
        h[0] = '0;              t[0] = '0;              u[0] = hand.digits[9];
        h[1] = hand.digits[8];  t[1] = hand.digits[7];  u[1] = hand.digits[6];
        h[2] = hand.digits[5];  t[2] = hand.digits[4];  u[2] = hand.digits[3];
        h[3] = hand.digits[2];  t[3] = hand.digits[1];  u[3] = hand.digits[0];
        scale[0] = TOK_BILLION;
        scale[1] = TOK_MILLION;
        scale[2] = TOK_THOUSAND;
        scale[3] = TOK_ZERO;
        all_zero = (hand.digits == '0);
    end

    // slots per group: digit, hundred, tens or teen, unit, scale
    always_comb
    begin
        for (int g = 0; g < 4; g++)
        begin
            mask_new[g*GROUP_SLOTS + 0] = (h[g] != 4'd0);
            tok_new[g*GROUP_SLOTS + 0]  = {1'b0, h[g]};
            mask_new[g*GROUP_SLOTS + 1] = (h[g] != 4'd0);
            tok_new[g*GROUP_SLOTS + 1]  = TOK_HUNDRED;
            mask_new[g*GROUP_SLOTS + 2] = (t[g] != 4'd0);
            tok_new[g*GROUP_SLOTS + 2]  = (t[g] == 4'd1) ? TOK_TEEN_BASE + {1'b0, u[g]}
                                                         : TOK_TENS_BASE + {1'b0, t[g]};
            mask_new[g*GROUP_SLOTS + 3] = (t[g] != 4'd1) && (u[g] != 4'd0);
            tok_new[g*GROUP_SLOTS + 3]  = {1'b0, u[g]};
            mask_new[g*GROUP_SLOTS + 4] = (g != 3) &&
                                          ((h[g] != 4'd0) || (t[g] != 4'd0) || (u[g] != 4'd0));
            tok_new[g*GROUP_SLOTS + 4]  = scale[g];
        end
        mask_new[SLOTS-1] = all_zero;
        tok_new[SLOTS-1]  = TOK_ZERO;
    end

    // lowest pending slot goes out next
    always_comb
    begin
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                idx = SLOT_IDX_W'(i);
            end
        end
        any       = |mask_reg;
        single    = ((mask_reg & (mask_reg - SLOTS'(1))) == '0);
        emit_free = single;
    end

    always_comb
    begin
        word_valid_next = any;
        word_next       = tok_reg[idx];
        last_word_next  = any && single;
        if (hand.load)
        begin
            mask_next = mask_new;
        end
        else
        begin
            mask_next = mask_reg & ~(SLOTS'(1) << idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg       <= '0;
            word_valid_reg <= 1'b0;
            last_word_reg  <= 1'b0;
        end
        else
        begin
            mask_reg       <= mask_next;
            word_valid_reg <= word_valid_next;
            last_word_reg  <= last_word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (hand.load)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                tok_reg[i] <= tok_new[i];
            end
        end
    end

    assign word_valid = word_valid_reg;
    assign word       = word_reg;
    assign last_word  = last_word_reg;

endmodule

// ===== hw/rtl/number_to_english_words.sv =====
// ----------------------------------------------------------------------------
// number_to_english_words
// spells a 31-bit unsigned number as a stream of english word tokens
// ----------------------------------------------------------------------------
// flow: after start is taken the number runs through the 16 two-bit steps of
//   the digit-cell chain, then words come out one per cycle, 1 to 16 words per
//   number, last_word on the final one; a new start is taken from the last step
//   on, and busy holds while more than one word of the last run is pending
// reset: rst_n clears all control, no words pending, busy low
// receiver cannot stall: each word is on the ports for exactly one cycle
module number_to_english_words
    import n2w_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [NUM_W-1:0] number,
    output logic             word_valid,
    output logic [4:0]       word,
    output logic             last_word
);

    conv_hand_t hand;       // digits handed from the converter to the sequencer
    logic       emit_free;  // sequencer can take new digits this cycle

    // binary to bcd: a chain of ten digit cells, two bits shifted per cycle,
    // digits are handed over on the last step or held until the sequencer frees
    n2w_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .number    (number),
        .emit_free (emit_free),
        .busy      (busy),
        .hand      (hand)
    );

    // word sequencer: marks every word slot of the spelling, then sends the
    // lowest pending one each cycle through a registered output
    n2w_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .hand       (hand),
        .emit_free  (emit_free),
        .word_valid (word_valid),
        .word       (word),
        .last_word  (last_word)
    );

endmodule

// ===== hw/rtl/n2w_checker.sv =====
// ----------------------------------------------------------------------------
// n2w_checker
// port-level checks on the number-to-words block
// ----------------------------------------------------------------------------
module n2w_checker
    import n2w_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       word_valid,
    input logic [4:0] word,
    input logic       last_word
);

    // a taken number keeps the block busy the next cycle
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after start");

    // words of one number come out back to back
    a_words_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !last_word |=> word_valid)
        else $error("gap inside a word run");

    // zero is only ever spelled alone
    a_zero_alone: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && (word == TOK_ZERO) |-> last_word && !$past(word_valid && !last_word))
        else $error("zero word inside a longer spelling");

    // hundred always follows a digit word of the same number
    a_hundred_after_digit: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && (word == TOK_HUNDRED) |->
            $past(word_valid) && !$past(last_word) && ($past(word) < TOK_TEEN_BASE))
        else $error("hundred not preceded by a digit");

endmodule

bind number_to_english_words n2w_checker u_n2w_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .word_valid (word_valid),
    .word       (word),
    .last_word  (last_word)
);
